>>> rtl/sapq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted array priority queue: shared package
// Opcodes, status codes, sequencer states and the result record that the
// sequencer hands to the top level.
// ----------------------------------------------------------------------------
package sapq_pkg;

   // Request opcodes. The unused code acts as a query.
   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_ENQUEUE = 2'd0;
   localparam opcode_type OP_DEQUEUE = 2'd1;
   localparam opcode_type OP_QUERY   = 2'd2;

   // Result status codes.
   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_OVERFLOW  = 2'd1;
   localparam status_type STATUS_UNDERFLOW = 2'd2;

   // Fixed widths of the result and capacity port fields.
   localparam int OUT_WIDTH = 32;
   localparam int OCC_WIDTH = 5;
   localparam int CSR_WIDTH = 5;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENQ_START,
      ST_ENQ_CMP,
      ST_DEQ_SHIFT,
      ST_DONE
   } state_type;

   // One result beat.
   typedef struct packed {
      logic                        valid;
      logic signed [OUT_WIDTH-1:0] removed_value;
      status_type                  status;
      logic signed [OUT_WIDTH-1:0] smallest;
      logic signed [OUT_WIDTH-1:0] largest;
      logic [OCC_WIDTH-1:0]        occupancy;
      logic                        is_empty;
      logic                        is_full;
   } rsp_type;

endpackage

>>> rtl/sapq_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted array priority queue: value store
// One write port and one read port with registered read data. Entries are
// undefined until written; the sequencer only reads entries it has filled.
// ----------------------------------------------------------------------------
module sapq_store
   import sapq_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [DATA_WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [DATA_WIDTH-1:0]         rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/sapq_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted array priority queue: sequencer
// Runs one operation at a time. Enqueue walks down from the rear, moving one
// larger entry up per cycle through the shared compare; dequeue moves one
// entry down per cycle. Front and rear values are kept in registers.
// ----------------------------------------------------------------------------
module sapq_seq
   import sapq_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  opcode_type                       opcode,
   input  logic [DATA_WIDTH-1:0]            value,
   input  logic [$clog2(DEPTH+1)-1:0]       capacity,
   output logic                             busy,
   output rsp_type                          rsp,
   output logic                             mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]         mem_wr_addr,
   output logic [DATA_WIDTH-1:0]            mem_wr_data,
   output logic [$clog2(DEPTH)-1:0]         mem_rd_addr,
   input  logic [DATA_WIDTH-1:0]            mem_rd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   state_type             state_ff, state_in;
   opcode_type            op_ff, op_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [DATA_WIDTH-1:0] front_ff, front_in;
   logic [DATA_WIDTH-1:0] rear_ff, rear_in;
   logic [DATA_WIDTH-1:0] removed_ff, removed_in;
   status_type            status_ff, status_in;

   logic [AW-1:0] idx_dec;
   logic [CW-1:0] idx_next_cnt;
   logic          rd_greater;
   logic          is_full;

   assign idx_dec      = idx_ff - AW'(1);
   assign idx_next_cnt = CW'(idx_ff) + CW'(1);
   // The one shared compare: stored entry against the value being placed.
   assign rd_greater   = $signed(mem_rd_data) > $signed(val_ff);
   assign is_full      = count_ff >= capacity;

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      val_ff     <= val_in;
      idx_ff     <= idx_in;
      front_ff   <= front_in;
      rear_ff    <= rear_in;
      removed_ff <= removed_in;
      status_ff  <= status_in;
   end

   // Next state, store accesses and register updates.
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      val_in      = val_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      front_in    = front_ff;
      rear_in     = rear_ff;
      removed_in  = removed_ff;
      status_in   = status_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = idx_ff;
      mem_wr_data = val_ff;
      mem_rd_addr = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in      = opcode;
               val_in     = value;
               removed_in = '1;
               status_in  = STATUS_OK;
               unique case (opcode)
                  OP_ENQUEUE: begin
                     if (is_full || count_ff >= CW'(DEPTH)) begin
                        status_in = STATUS_OVERFLOW;
                        state_in  = ST_DONE;
                     end else begin
                        idx_in   = AW'(count_ff);
                        state_in = ST_ENQ_START;
                     end
                  end
                  OP_DEQUEUE: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_UNDERFLOW;
                        state_in  = ST_DONE;
                     end else if (count_ff == CW'(1)) begin
                        removed_in = front_ff;
                        count_in   = '0;
                        state_in   = ST_DONE;
                     end else begin
                        // Fetch the second entry; it becomes the new front.
                        removed_in  = front_ff;
                        mem_rd_addr = AW'(1);
                        idx_in      = AW'(1);
                        state_in    = ST_DEQ_SHIFT;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // Place the value at the bottom slot, or fetch the entry below.
         ST_ENQ_START: begin
            if (idx_ff == '0) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = '0;
               mem_wr_data = val_ff;
               front_in    = val_ff;
               if (count_ff == '0) begin
                  rear_in = val_ff;
               end
               count_in = count_ff + CW'(1);
               state_in = ST_DONE;
            end else begin
               mem_rd_addr = idx_dec;
               state_in    = ST_ENQ_CMP;
            end
         end

         // Move a larger entry up one slot, or drop the value in place.
         ST_ENQ_CMP: begin
            mem_wr_en = 1'b1;
            if (rd_greater) begin
               mem_wr_data = mem_rd_data;
               idx_in      = idx_dec;
               if (idx_ff == AW'(1)) begin
                  state_in = ST_ENQ_START;
               end else begin
                  mem_rd_addr = idx_dec - AW'(1);
               end
            end else begin
               mem_wr_data = val_ff;
               if (CW'(idx_ff) == count_ff) begin
                  rear_in = val_ff;
               end
               count_in = count_ff + CW'(1);
               state_in = ST_DONE;
            end
         end

         // Move one entry down a slot per cycle.
         ST_DEQ_SHIFT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = idx_dec;
            mem_wr_data = mem_rd_data;
            if (idx_ff == AW'(1)) begin
               front_in = mem_rd_data;
            end
            if (idx_next_cnt < count_ff) begin
               mem_rd_addr = idx_ff + AW'(1);
               idx_in      = idx_ff + AW'(1);
            end else begin
               count_in = count_ff - CW'(1);
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   // Result beat, shown for the one cycle in the done state.
   always_comb begin
      rsp.valid         = (state_ff == ST_DONE);
      rsp.removed_value = OUT_WIDTH'($signed(removed_ff));
      rsp.status        = status_ff;
      rsp.smallest      = (count_ff == '0) ? '1 : OUT_WIDTH'($signed(front_ff));
      rsp.largest       = (count_ff == '0) ? '1 : OUT_WIDTH'($signed(rear_ff));
      rsp.occupancy     = OCC_WIDTH'(count_ff);
      rsp.is_empty      = (count_ff == '0);
      rsp.is_full       = is_full;
   end

   // The held count never passes the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("held count exceeds depth");

   // An accepted request always leaves the idle state.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not start a sequence");

   // A result beat is followed by the idle state.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |=> !busy)
      else $error("sequencer stayed busy after a result");

   // Overflow is reported only on a full queue.
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status == STATUS_OVERFLOW |-> rsp.is_full)
      else $error("overflow reported on a queue that is not full");

   // Writes stay inside the occupied region plus the slot being filled.
   a_write_range: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> CW'(mem_wr_addr) <= count_ff)
      else $error("store write outside the occupied region");

endmodule

>>> rtl/sorted_array_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted array priority queue
// Bounded min-priority queue held as an ascending sorted array, with a
// capacity register, stable ordering among equal values and status flags.
// ----------------------------------------------------------------------------
// Sequence: query, overflow, underflow and a dequeue of the last value go
//   straight to the result; other dequeues shift later entries down one per
//   cycle; an enqueue moves k larger entries up one per cycle, then places
//   the value. Flow: one request at a time; busy holds through the result
//   beat, and the receiver cannot stall.
// Reset: synchronous; empties the queue and sets the capacity to 16.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue
   import sapq_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_opcode,
   input  logic signed [31:0]          req_value_in,
   output logic                        rsp_valid,
   output logic signed [31:0]          rsp_removed_value,
   output logic [1:0]                  rsp_status,
   output logic signed [31:0]          rsp_smallest,
   output logic signed [31:0]          rsp_largest,
   output logic [4:0]                  rsp_occupancy,
   output logic                        rsp_is_empty,
   output logic                        rsp_is_full,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [4:0]                  csr_capacity_in_use
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > CSR_WIDTH) ? CW : CSR_WIDTH;

   logic [CSR_WIDTH-1:0]  capacity_ff, capacity_in;
   logic [XW-1:0]         capacity_x;
   logic [CW-1:0]         capacity_eff;
   logic [DATA_WIDTH-1:0] value_trim;
   rsp_type               rsp;
   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   logic [DATA_WIDTH-1:0] mem_wr_data;
   logic [AW-1:0]         mem_rd_addr;
   logic [DATA_WIDTH-1:0] mem_rd_data;

   // Capacity register; a write beat is always taken.
   assign csr_ready   = 1'b1;
   assign capacity_in = (csr_valid && csr_ready) ? csr_capacity_in_use : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CSR_WIDTH'(16);
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // Effective capacity: zero acts as one, and it saturates at the depth.
   assign capacity_x = XW'(capacity_ff);
   always_comb begin
      priority if (capacity_x == '0) begin
         capacity_eff = CW'(1);
      end else if (capacity_x > XW'(DEPTH)) begin
         capacity_eff = CW'(DEPTH);
      end else begin
         capacity_eff = CW'(capacity_x);
      end
   end

   // The value is taken as its low DATA_WIDTH bits.
   assign value_trim = DATA_WIDTH'($unsigned(req_value_in));

   sapq_seq #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .opcode      (req_opcode),
      .value       (value_trim),
      .capacity    (capacity_eff),
      .busy        (busy),
      .rsp         (rsp),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   sapq_store #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Result ports.
   assign rsp_valid         = rsp.valid;
   assign rsp_removed_value = rsp.removed_value;
   assign rsp_status        = rsp.status;
   assign rsp_smallest      = rsp.smallest;
   assign rsp_largest       = rsp.largest;
   assign rsp_occupancy     = rsp.occupancy;
   assign rsp_is_empty      = rsp.is_empty;
   assign rsp_is_full       = rsp.is_full;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the sorted array priority queue
// A queue-fed driver issues enqueue, dequeue and query commands and capacity
// writes. A shadow sorted list predicts each result beat, and a monitor
// compares every strobed result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top
   import sapq_pkg::*;
();

   localparam opcode_type OP_UNUSED   = 2'd3;
   localparam int         PHASE_ITEMS = 250;
   localparam int         STALL_LIMIT = 5000;
   localparam int         TAIL_CYCLES = 40;
   localparam logic signed [31:0] EMPTY_MARK = -32'sd1;
   localparam logic signed [31:0] MAX_VALUE  = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MIN_VALUE  = 32'sh8000_0000;

   // One pending driver step: a command beat, a capacity write, or a pause
   // until every predicted result has arrived.
   typedef enum logic [1:0] {
      STEP_COMMAND,
      STEP_CAPACITY,
      STEP_DRAIN
   } step_kind_type;

   typedef struct {
      step_kind_type            kind;
      opcode_type               opcode;
      logic signed [31:0]       value;
      logic [CSR_WIDTH-1:0]     capacity;
      int                       idle_pct;
   } step_type;

   typedef struct {
      logic signed [31:0]       removed_value;
      status_type               status;
      logic signed [31:0]       smallest;
      logic signed [31:0]       largest;
      logic [OCC_WIDTH-1:0]     occupancy;
      logic                     is_empty;
      logic                     is_full;
   } queue_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [1:0]                  req_opcode = OP_QUERY;
   logic signed [31:0]          req_value_in = '0;
   logic                        rsp_valid;
   logic signed [31:0]          rsp_removed_value;
   logic [1:0]                  rsp_status;
   logic signed [31:0]          rsp_smallest;
   logic signed [31:0]          rsp_largest;
   logic [4:0]                  rsp_occupancy;
   logic                        rsp_is_empty;
   logic                        rsp_is_full;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [4:0]                  csr_capacity_in_use = '0;

   step_type                    pending_steps[$];
   queue_result_type            awaited_results[$];
   logic signed [31:0]          shadow_values[$];
   logic [CSR_WIDTH-1:0]        shadow_capacity;
   int                          failures = 0;
   int                          stall_cycles = 0;

   sorted_array_priority_queue DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_value_in        (req_value_in),
      .rsp_valid           (rsp_valid),
      .rsp_removed_value   (rsp_removed_value),
      .rsp_status          (rsp_status),
      .rsp_smallest        (rsp_smallest),
      .rsp_largest         (rsp_largest),
      .rsp_occupancy       (rsp_occupancy),
      .rsp_is_empty        (rsp_is_empty),
      .rsp_is_full         (rsp_is_full),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_capacity_in_use (csr_capacity_in_use)
   );

   always #5 clock = ~clock;

   // Apply one command to the shadow sorted list and return the result beat
   // that the queue should produce for it.
   function automatic queue_result_type apply_queue_command(opcode_type op,
                                                            logic signed [31:0] value);
      queue_result_type r;
      int               limit;
      int               slot;
      limit = (shadow_capacity == 0) ? 1 : (shadow_capacity > 16) ? 16 : shadow_capacity;
      r.removed_value = EMPTY_MARK;
      r.status = STATUS_OK;
      if (op == OP_ENQUEUE) begin
         if (shadow_values.size() >= limit) begin
            r.status = STATUS_OVERFLOW;
         end else begin
            // Equal values keep arrival order: insert after the last one.
            slot = shadow_values.size();
            while (slot > 0 && shadow_values[slot-1] > value) slot--;
            shadow_values.insert(slot, value);
         end
      end else if (op == OP_DEQUEUE) begin
         if (shadow_values.size() == 0) begin
            r.status = STATUS_UNDERFLOW;
         end else begin
            r.removed_value = shadow_values.pop_front();
         end
      end
      r.smallest  = (shadow_values.size() == 0) ? EMPTY_MARK : shadow_values[0];
      r.largest   = (shadow_values.size() == 0) ? EMPTY_MARK : shadow_values[$];
      r.occupancy = OCC_WIDTH'(shadow_values.size());
      r.is_empty  = (shadow_values.size() == 0);
      r.is_full   = (shadow_values.size() >= limit);
      return r;
   endfunction

   // Driver: the command and capacity channels, fed from the pending steps.
   always @(posedge clock) begin : drive_proc
      logic     start_next;
      logic     csr_next;
      step_type head;
      if (reset) begin
         start <= 1'b0;
         csr_valid <= 1'b0;
         req_opcode <= OP_QUERY;
         req_value_in <= '0;
         csr_capacity_in_use <= '0;
         shadow_values.delete();
         shadow_capacity = 5'd16;
         awaited_results.delete();
      end else begin
         start_next = start;
         csr_next = csr_valid;
         // A command beat is taken: predict its result now.
         if (start && !busy) begin
            awaited_results.push_back(apply_queue_command(req_opcode, req_value_in));
            start_next = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            shadow_capacity = csr_capacity_in_use;
            csr_next = 1'b0;
         end
         // The queue is idle only with nothing awaited and no beat on the wire.
         if (!start_next && !csr_next && pending_steps.size() > 0) begin
            head = pending_steps[0];
            case (head.kind)
               STEP_COMMAND: begin
                  if ($urandom_range(99) >= head.idle_pct) begin
                     req_opcode <= head.opcode;
                     req_value_in <= head.value;
                     start_next = 1'b1;
                     void'(pending_steps.pop_front());
                  end
               end
               STEP_CAPACITY: begin
                  if (!start && !busy && !rsp_valid && awaited_results.size() == 0) begin
                     csr_capacity_in_use <= head.capacity;
                     csr_next = 1'b1;
                     void'(pending_steps.pop_front());
                  end
               end
               default: begin
                  if (!start && !busy && !rsp_valid && awaited_results.size() == 0) begin
                     void'(pending_steps.pop_front());
                  end
               end
            endcase
         end
         start <= start_next;
         csr_valid <= csr_next;
      end
   end

   task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d (0x%08h), got %0d (0x%08h)", name, want, want, got, got);
         failures++;
      end
   endtask

   // Monitor: every result beat is matched against the oldest prediction.
   always @(posedge clock) begin : watch_proc
      queue_result_type want;
      if (!reset && rsp_valid) begin
         if (awaited_results.size() == 0) begin
            $error("result beat with no prediction waiting");
            failures++;
         end else begin
            want = awaited_results.pop_front();
            check_field("removed_value", want.removed_value, rsp_removed_value);
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("smallest", want.smallest, rsp_smallest);
            check_field("largest", want.largest, rsp_largest);
            check_field("occupancy", 32'(want.occupancy), 32'(rsp_occupancy));
            check_field("is_empty", 32'(want.is_empty), 32'(rsp_is_empty));
            check_field("is_full", 32'(want.is_full), 32'(rsp_is_full));
         end
      end
   end

   // Watchdog on cycles in which no beat of any kind moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic add_command(opcode_type op, logic signed [31:0] value, int idle_pct);
      step_type s;
      s.kind = STEP_COMMAND;
      s.opcode = op;
      s.value = value;
      s.capacity = '0;
      s.idle_pct = idle_pct;
      pending_steps.push_back(s);
   endtask

   task automatic add_capacity(logic [CSR_WIDTH-1:0] cap);
      step_type s;
      s.kind = STEP_CAPACITY;
      s.opcode = OP_QUERY;
      s.value = '0;
      s.capacity = cap;
      s.idle_pct = 0;
      pending_steps.push_back(s);
   endtask

   task automatic add_drain();
      step_type s;
      s.kind = STEP_DRAIN;
      s.opcode = OP_QUERY;
      s.value = '0;
      s.capacity = '0;
      s.idle_pct = 0;
      pending_steps.push_back(s);
   endtask

   // Four values in ten fall in a narrow band so that ties are common; one
   // in ten is an extreme and the rest are fully random words.
   function automatic logic signed [31:0] pick_value();
      int pick;
      pick = $urandom_range(9);
      if (pick < 4) return $signed($urandom_range(15)) - 32'sd8;
      if (pick == 4) return $urandom_range(1) ? MAX_VALUE : MIN_VALUE;
      return $urandom;
   endfunction

   initial begin : stimulus_proc
      int          phase_idle[4];
      logic [4:0]  phase_cap[4];
      int          enq_pct;
      int          roll;
      opcode_type  op;
      phase_idle = '{0, 88, 0, 30};
      phase_cap = '{5'd16, 5'd31, 5'd4, 5'd9};

      // Directed: empty queue behavior and the unused opcode.
      add_command(OP_QUERY, 32'sd0, 0);
      add_command(OP_DEQUEUE, 32'sd0, 0);
      add_command(OP_UNUSED, MAX_VALUE, 0);
      // Extreme values and a tie, then drain them in order.
      add_command(OP_ENQUEUE, MAX_VALUE, 0);
      add_command(OP_ENQUEUE, MIN_VALUE, 0);
      add_command(OP_ENQUEUE, -32'sd1, 0);
      add_command(OP_ENQUEUE, 32'sd0, 0);
      add_command(OP_ENQUEUE, 32'sd5, 0);
      add_command(OP_ENQUEUE, 32'sd5, 0);
      repeat (6) add_command(OP_DEQUEUE, 32'sd0, 0);
      // A zero capacity acts as one.
      add_capacity(5'd0);
      add_command(OP_ENQUEUE, 32'sd7, 0);
      add_command(OP_ENQUEUE, 32'sd8, 0);
      add_command(OP_DEQUEUE, 32'sd0, 0);
      // Capacity lowered below the count: full, but dequeue still works.
      add_capacity(5'd2);
      add_command(OP_ENQUEUE, 32'sd3, 0);
      add_command(OP_ENQUEUE, -32'sd3, 0);
      add_command(OP_ENQUEUE, 32'sd9, 0);
      add_capacity(5'd1);
      add_command(OP_ENQUEUE, 32'sd1, 0);
      add_command(OP_DEQUEUE, 32'sd0, 0);
      add_command(OP_DEQUEUE, 32'sd0, 0);

      // Random phases. The result side cannot stall, so the receiver phase
      // runs without sender gaps. Bias switches among filling, emptying and balanced
      // so that the full and empty edges are reached often.
      for (int phase = 0; phase < 4; phase++) begin
         add_drain();
         add_capacity(phase_cap[phase]);
         enq_pct = 50;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 30 == 0) begin
               roll = $urandom_range(2);
               enq_pct = (roll == 0) ? 85 : (roll == 1) ? 15 : 50;
            end
            if (n == PHASE_ITEMS / 2) add_drain();
            roll = $urandom_range(99);
            if (roll < 4) op = OP_QUERY;
            else if (roll < 6) op = OP_UNUSED;
            else op = ($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
            add_command(op, pick_value(), phase_idle[phase]);
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Sample away from the active edge so the queue sizes are settled.
      do @(negedge clock);
      while (pending_steps.size() != 0 || start || csr_valid || busy ||
             awaited_results.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0) begin
         $error("%0d predicted results never arrived", awaited_results.size());
         failures++;
      end
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
